FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the LRU replacement block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// Types, constants and field widths shared by the LRU replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

	// parameter defaults
	localparam int FRAMES_DEF     = 16;
	localparam int PAGE_BITS_DEF  = 16;
	localparam int STAMP_BITS_DEF = 16;

	// fixed field widths
	localparam int PAGE_W   = 16;
	localparam int FIDX_W   = 4;
	localparam int FAULT_W  = 16;
	localparam int CFG_W    = 5;

	localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_COMMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;  // latch the incoming page
		logic search;  // compare frames and pick the victim
		logic commit;  // write back frame state and load the result
	} cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lru_if.sv
// ----------------------------------------------------------------------------
// lru_if
// Valid/ready channels for page references and replacement results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lru_req_if;
	logic                        valid;
	logic                        ready;
	logic [lru_pkg::PAGE_W-1:0]  page;

	modport source (output valid, output page, input ready);
	modport sink   (input valid, input page, output ready);
endinterface

interface lru_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [lru_pkg::FIDX_W-1:0]  frame_index;
	logic                        evicted_valid;
	logic [lru_pkg::PAGE_W-1:0]  evicted_page;
	logic [lru_pkg::FAULT_W-1:0] fault_total;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_total, input ready);
	modport sink   (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_total, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement: one result per page reference.
//
//   channel  dir  handshake      payload
//   cfg      in   cfg_wr_en      cfg_wr_data (frames_in_use)
//   req      in   valid/ready    page
//   rsp      out  valid/ready    hit, frame_index, evicted_valid,
//                                evicted_page, fault_total
//
// A reference runs through a search state, which compares every frame against
// the page and runs the oldest-stamp tree over the frames, and a commit state,
// which writes the frame back and loads the result register. The next reference
// is taken in the commit state, so its acceptance overlaps the last write-back.
// Write-back stalls while the result register is full and not being taken.
// Reset clears stamps, counters and control; frame pages need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
	parameter int FRAMES     = lru_pkg::FRAMES_DEF,
	parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
	parameter int STAMP_BITS = lru_pkg::STAMP_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [lru_pkg::CFG_W-1:0] cfg_wr_data,
	lru_req_if.sink                        req,
	lru_rsp_if.source                      rsp
);

	lru_pkg::cmd_t cmd;

	lru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	lru_datapath #(
		.FRAMES     (FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (cmd),
		.page          (req.page),
		.hit           (rsp.hit),
		.frame_index   (rsp.frame_index),
		.evicted_valid (rsp.evicted_valid),
		.evicted_page  (rsp.evicted_page),
		.fault_total   (rsp.fault_total)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/lru_ctrl.sv
// ----------------------------------------------------------------------------
// lru_ctrl
// Sequencer: accept a reference, search the frames, then commit the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lru_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output lru_pkg::cmd_t      cmd
);

	lru_pkg::state_t state_q, state_d;
	logic            rsp_valid_q;
	logic            commit_go;

	// result register free, or drained this cycle
	assign commit_go = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lru_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd        = '0;
		case (state_q)
			lru_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = lru_pkg::S_SEARCH;
				end
			end
			lru_pkg::S_SEARCH: begin
				cmd.search = 1'b1;
				state_d    = lru_pkg::S_COMMIT;
			end
			lru_pkg::S_COMMIT: begin
				// hold until the result register can take the transfer
				if (commit_go) begin
					cmd.commit = 1'b1;
					req_ready  = 1'b1;
					if (req_valid) begin
						cmd.accept = 1'b1;
						state_d    = lru_pkg::S_SEARCH;
					end else begin
						state_d = lru_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = lru_pkg::S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	`ASSERT_NEXT(a_accept_to_search, clk, arst_n, req_valid && req_ready, state_q == lru_pkg::S_SEARCH)
	`ASSERT_NEXT(a_search_to_commit, clk, arst_n, state_q == lru_pkg::S_SEARCH, state_q == lru_pkg::S_COMMIT)
	`ASSERT_NEXT(a_commit_shows_result, clk, arst_n, cmd.commit, rsp_valid_q)

endmodule

`default_nettype wire

FILE: hw/rtl/lru_datapath.sv
// ----------------------------------------------------------------------------
// lru_datapath
// Frame table, parallel page compare, oldest-stamp tree and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lru_datapath #(
	parameter int FRAMES     = lru_pkg::FRAMES_DEF,
	parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
	parameter int STAMP_BITS = lru_pkg::STAMP_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [lru_pkg::CFG_W-1:0]     cfg_wr_data,
	input  wire lru_pkg::cmd_t                 cmd,
	input  wire logic [lru_pkg::PAGE_W-1:0]    page,
	output logic                               hit,
	output logic [lru_pkg::FIDX_W-1:0]         frame_index,
	output logic                               evicted_valid,
	output logic [lru_pkg::PAGE_W-1:0]         evicted_page,
	output logic [lru_pkg::FAULT_W-1:0]        fault_total
);

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W  = $clog2(FRAMES + 1);
	localparam int LEAVES = 1 << IDX_W;
	localparam int NODES  = 2 * LEAVES - 1;

	localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

	// architectural state
	logic [lru_pkg::CFG_W-1:0]   frames_in_use_q;
	logic [PAGE_BITS-1:0]        frame_page_q  [FRAMES];
	logic [STAMP_BITS-1:0]       frame_stamp_q [FRAMES];
	logic [CNT_W-1:0]            filled_count_q;
	logic [STAMP_BITS-1:0]       reference_count_q;
	logic [lru_pkg::FAULT_W-1:0] fault_count_q;
	logic [PAGE_BITS-1:0]        page_q;

	// search results
	logic                        hit_s1;
	logic                        evict_s1;
	logic                        fill_s1;
	logic [IDX_W-1:0]            slot_s1;
	logic [PAGE_BITS-1:0]        old_page_s1;
	logic [CNT_W-1:0]            filled_s1;

	// search logic
	logic [CNT_W-1:0]            n_eff;
	logic [CNT_W-1:0]            filled;
	logic                        full;
	logic [FRAMES-1:0]           match;
	logic                        any_match;
	logic [IDX_W-1:0]            match_idx;
	logic [IDX_W-1:0]            slot;
	logic [lru_pkg::FAULT_W-1:0] fault_next;

	logic                        nd_ok    [NODES];
	logic [STAMP_BITS-1:0]       nd_stamp [NODES];
	logic [PAGE_BITS-1:0]        nd_page  [NODES];
	logic [IDX_W-1:0]            nd_idx   [NODES];

	// clamp the frame count into 1..FRAMES
	always_comb begin
		if (frames_in_use_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(frames_in_use_q) > FRAMES) begin
			n_eff = CNT_W'(FRAMES);
		end else begin
			n_eff = CNT_W'(frames_in_use_q);
		end
		filled = (filled_count_q < n_eff) ? filled_count_q : n_eff;
		full   = (filled == n_eff);
	end

	// parallel compare over filled frames, lowest index wins
	always_comb begin
		match_idx = '0;
		for (int i = 0; i < FRAMES; i++) begin
			match[i] = (frame_page_q[i] == page_q) && (CNT_W'(i) < filled);
		end
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				match_idx = IDX_W'(i);
			end
		end
		any_match = |match;
	end

	// oldest-stamp tree; the left child holds lower frames, so it wins ties
	always_comb begin
		for (int j = 0; j < FRAMES; j++) begin
			nd_ok[LEAVES-1+j]    = CNT_W'(j) < n_eff;
			nd_stamp[LEAVES-1+j] = frame_stamp_q[j];
			nd_page[LEAVES-1+j]  = frame_page_q[j];
			nd_idx[LEAVES-1+j]   = IDX_W'(j);
		end
		for (int j = FRAMES; j < LEAVES; j++) begin
			nd_ok[LEAVES-1+j]    = 1'b0;
			nd_stamp[LEAVES-1+j] = '0;
			nd_page[LEAVES-1+j]  = '0;
			nd_idx[LEAVES-1+j]   = IDX_W'(j);
		end
		for (int k = LEAVES - 2; k >= 0; k--) begin
			if (nd_ok[2*k+1] && (!nd_ok[2*k+2] || nd_stamp[2*k+1] <= nd_stamp[2*k+2])) begin
				nd_stamp[k] = nd_stamp[2*k+1];
				nd_page[k]  = nd_page[2*k+1];
				nd_idx[k]   = nd_idx[2*k+1];
			end else begin
				nd_stamp[k] = nd_stamp[2*k+2];
				nd_page[k]  = nd_page[2*k+2];
				nd_idx[k]   = nd_idx[2*k+2];
			end
			nd_ok[k] = nd_ok[2*k+1] || nd_ok[2*k+2];
		end
	end

	always_comb begin
		if (any_match) begin
			slot = match_idx;
		end else if (full) begin
			slot = nd_idx[0];
		end else begin
			slot = IDX_W'(filled);
		end
	end

	assign fault_next = (!hit_s1 && fault_count_q != lru_pkg::FAULT_MAX) ?
		fault_count_q + lru_pkg::FAULT_W'(1) : fault_count_q;

	// control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q   <= lru_pkg::CFG_RESET;
			filled_count_q    <= '0;
			reference_count_q <= '0;
			fault_count_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				frames_in_use_q <= cfg_wr_data;
			end
			if (cmd.search && reference_count_q != STAMP_MAX) begin
				reference_count_q <= reference_count_q + STAMP_BITS'(1);
			end
			if (cmd.commit) begin
				fault_count_q <= fault_next;
				if (fill_s1) begin
					filled_count_q <= filled_s1 + CNT_W'(1);
				end
			end
		end
	end

	// stamps reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				frame_stamp_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			frame_stamp_q[slot_s1] <= reference_count_q;
		end
	end

	// resident pages: only filled frames are ever compared
	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_s1) begin
			frame_page_q[slot_s1] <= page_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			page_q <= PAGE_BITS'(page);
		end
		if (cmd.search) begin
			hit_s1      <= any_match;
			evict_s1    <= !any_match && full;
			fill_s1     <= !any_match && !full;
			slot_s1     <= slot;
			old_page_s1 <= nd_page[0];
			filled_s1   <= filled;
		end
		if (cmd.commit) begin
			hit           <= hit_s1;
			frame_index   <= lru_pkg::FIDX_W'(slot_s1);
			evicted_valid <= evict_s1;
			evicted_page  <= evict_s1 ? lru_pkg::PAGE_W'(old_page_s1) : '0;
			fault_total   <= fault_next;
		end
	end

	`ASSERT_IMPLIES(a_filled_bound, clk, arst_n, 1'b1, 32'(filled_count_q) <= FRAMES)
	`ASSERT_IMPLIES(a_evict_is_fault, clk, arst_n, cmd.commit && evict_s1, !hit_s1 && !fill_s1)
	`ASSERT_NEXT(a_hit_keeps_faults, clk, arst_n, cmd.commit && hit_s1, fault_count_q == $past(fault_count_q))

endmodule

`default_nettype wire

FILE: tb/tb_lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement
// Self-checking bench for the LRU page replacement block. A shadow of the
// frame table predicts hit, frame, eviction and fault count for every page
// transfer. Results are compared in order against those predictions. Random
// gaps and stalls run on both channels. The frame count is swept over its
// extremes, including shrinking it below the filled count.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic                        hit;
	logic [lru_pkg::FIDX_W-1:0]  frame_index;
	logic                        evicted_valid;
	logic [lru_pkg::PAGE_W-1:0]  evicted_page;
	logic [lru_pkg::FAULT_W-1:0] fault_total;
} lru_outcome_t;

class lru_tracker;
	localparam int NFRAMES = lru_pkg::FRAMES_DEF;

	logic [lru_pkg::PAGE_W-1:0]         frame_pg [NFRAMES];
	logic [lru_pkg::STAMP_BITS_DEF-1:0] frame_ts [NFRAMES];
	logic [4:0]                         filled_cnt;
	logic [lru_pkg::STAMP_BITS_DEF-1:0] ref_cnt;
	logic [lru_pkg::FAULT_W-1:0]        fault_cnt;
	logic [lru_pkg::CFG_W-1:0]          frames_cfg;
	lru_outcome_t                       outstanding[$];
	int                                 failures;

	function new();
		foreach (frame_pg[i]) begin
			frame_pg[i] = '0;
			frame_ts[i] = '0;
		end
		filled_cnt = '0;
		ref_cnt    = '0;
		fault_cnt  = '0;
		frames_cfg = lru_pkg::CFG_RESET;
		failures   = 0;
	endfunction

	function void set_frames(logic [lru_pkg::CFG_W-1:0] v);
		frames_cfg = v;
	endfunction

	function int pending();
		return outstanding.size();
	endfunction

	function void flag(string what, longint unsigned expv, longint unsigned gotv);
		failures++;
		$error("%s: expected %0h, got %0h", what, expv, gotv);
	endfunction

	function void note_reference(logic [lru_pkg::PAGE_W-1:0] page);
		lru_outcome_t e;
		int n;
		int filled;
		int slot;
		bit found;
		logic [lru_pkg::STAMP_BITS_DEF-1:0] oldest;
		n = int'(frames_cfg);
		if (n < 1) n = 1;
		if (n > NFRAMES) n = NFRAMES;
		filled = (int'(filled_cnt) < n) ? int'(filled_cnt) : n;
		if (ref_cnt != '1) ref_cnt++;
		found = 1'b0;
		slot  = 0;
		for (int i = 0; i < filled; i++) begin
			if (!found && frame_pg[i] == page) begin
				found = 1'b1;
				slot  = i;
			end
		end
		e = '0;
		if (found) begin
			frame_ts[slot] = ref_cnt;
		end else begin
			if (filled < n) begin
				slot       = filled;
				filled_cnt = 5'(filled + 1);
			end else begin
				// oldest stamp wins, lowest frame on ties
				oldest = frame_ts[0];
				slot   = 0;
				for (int i = 1; i < n; i++) begin
					if (frame_ts[i] < oldest) begin
						oldest = frame_ts[i];
						slot   = i;
					end
				end
				e.evicted_valid = 1'b1;
				e.evicted_page  = frame_pg[slot];
			end
			frame_pg[slot] = page;
			frame_ts[slot] = ref_cnt;
			if (fault_cnt != '1) fault_cnt++;
		end
		e.hit         = found;
		e.frame_index = 4'(slot);
		e.fault_total = fault_cnt;
		outstanding.push_back(e);
	endfunction

	function void check_result(lru_outcome_t got);
		lru_outcome_t e;
		if (outstanding.size() == 0) begin
			failures++;
			$error("result transfer with no page reference outstanding");
			return;
		end
		e = outstanding.pop_front();
		if (got.hit !== e.hit) flag("hit", e.hit, got.hit);
		if (got.frame_index !== e.frame_index)
			flag("frame_index", e.frame_index, got.frame_index);
		if (got.evicted_valid !== e.evicted_valid)
			flag("evicted_valid", e.evicted_valid, got.evicted_valid);
		if (got.evicted_page !== e.evicted_page)
			flag("evicted_page", e.evicted_page, got.evicted_page);
		if (got.fault_total !== e.fault_total)
			flag("fault_total", e.fault_total, got.fault_total);
	endfunction
endclass

module tb_lru_page_replacement;
	localparam int QUIET_LIMIT = 4000;
	localparam int LONG_HOLD   = 150;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [lru_pkg::CFG_W-1:0] cfg_wr_data;

	lru_req_if req();
	lru_rsp_if rsp();

	lru_page_replacement dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp)
	);

	lru_tracker                 tracker;
	bit                         idle_on;
	bit                         long_hold_req;
	int                         quiet_cycles;
	logic [lru_pkg::PAGE_W-1:0] hot_pages [24];
	int                         hot_count;

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [lru_pkg::PAGE_W-1:0] pick_page();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return hot_pages[$urandom_range(0, hot_count - 1)];
		if (r < 73) return '0;
		if (r < 76) return '1;
		return lru_pkg::PAGE_W'($urandom);
	endfunction

	task automatic send_ref(input logic [lru_pkg::PAGE_W-1:0] page, input int unsigned gap);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.page  <= page;
		do @(posedge clk); while (!req.ready);
		tracker.note_reference(page);
	endtask

	// hold the sender until every outstanding result has been taken
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	task automatic write_frames(input logic [lru_pkg::CFG_W-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_frames(v);
	endtask

	task automatic run_phase(input int count);
		hot_count = $urandom_range(2, 24);
		foreach (hot_pages[i]) hot_pages[i] = lru_pkg::PAGE_W'($urandom);
		repeat (count) send_ref(pick_page(), pick_gap());
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		lru_outcome_t got;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got.hit           = rsp.hit;
				got.frame_index   = rsp.frame_index;
				got.evicted_valid = rsp.evicted_valid;
				got.evicted_page  = rsp.evicted_page;
				got.fault_total   = rsp.fault_total;
				tracker.check_result(got);
			end
			if (long_hold_req) begin
				stall_left    = LONG_HOLD;
				long_hold_req = 1'b0;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("lru_page_replacement test failed");
			$finish;
		end
	end

	initial begin
		logic [lru_pkg::CFG_W-1:0] sweep [10];
		tracker       = new();
		idle_on       = 1'b0;
		long_hold_req = 1'b0;
		quiet_cycles  = 0;
		hot_count     = 1;
		foreach (hot_pages[i]) hot_pages[i] = '0;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		req.valid   <= 1'b0;
		req.page    <= '0;
		rsp.ready   <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// fill from reset, hits on both page extremes
		send_ref(16'h0000, 0);
		send_ref(16'hFFFF, 0);
		send_ref(16'h0000, 0);
		send_ref(16'h5555, 0);
		send_ref(16'hAAAA, 0);
		send_ref(16'hFFFF, 0);
		// shrink below the filled count: upper frames drop out of the search
		write_frames(5'd2);
		send_ref(16'h5555, 0);
		send_ref(16'h0000, 0);
		send_ref(16'h1234, 0);
		send_ref(16'h0000, 0);
		// zero acts as a single frame
		write_frames(5'd0);
		send_ref(16'h0007, 0);
		send_ref(16'h0007, 0);
		send_ref(16'h0008, 0);
		// above the frame count acts as all frames; old upper frames come back
		write_frames(5'd31);
		send_ref(16'hAAAA, 0);
		send_ref(16'h0008, 0);
		send_ref(16'hFFFF, 0);
		write_frames(5'd1);
		send_ref(16'h8000, 0);
		write_frames(5'd17);
		send_ref(16'h0001, 0);

		sweep = '{5'd16, 5'd1, 5'd31, 5'd4, 5'($urandom_range(0, 31)), 5'd0, 5'd8,
			5'($urandom_range(0, 31)), 5'd17, 5'd2};
		foreach (sweep[ph]) begin
			write_frames(sweep[ph]);
			idle_on = (ph != 3);
			if (ph == 5) begin
				// stall the result side while references keep coming
				long_hold_req = 1'b1;
				idle_on       = 1'b0;
				run_phase(30);
				idle_on = 1'b1;
				run_phase(20);
			end else begin
				run_phase(40);
			end
		end

		write_frames(5'd16);
		idle_on = 1'b1;
		run_phase(40);
		write_frames(5'd5);
		run_phase(40);

		drain();
		repeat (20) @(posedge clk);
		if (tracker.pending() != 0) begin
			tracker.failures++;
			$error("%0d expected results never arrived", tracker.pending());
		end
		if (tracker.failures == 0)
			$display("lru_page_replacement test passed");
		else
			$display("lru_page_replacement test failed");
		$finish;
	end
endmodule
